// ----- hw/rtl/cjt_pkg.sv -----
// Shared types, constants and fixed-point helpers of the cubic joint trajectory generator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package cjt_pkg;

  // Defaults of the top-level parameters
  localparam int MAX_STEPS_DEF   = 64;
  localparam int JOINT_COUNT_DEF = 7;
  localparam int JOB_DEPTH_DEF   = 2;

  // Field widths
  localparam int NSTEP_W    = 7;
  localparam int DT_W       = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STEPS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAD_COEFF  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CUBIC_COEFF = 2'd3;

  // Register reset values
  localparam logic [NSTEP_W-1:0] NUM_STEPS_RST   = 7'd50;
  localparam logic [DT_W-1:0]    STEP_TIME_RST   = 20'd6554;
  localparam logic signed [31:0] QUAD_COEFF_RST  = 32'sd2013266;
  localparam logic signed [31:0] CUBIC_COEFF_RST = -32'sd268435;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [2:0]         joint_id;
    logic signed [31:0] start_angle;
    logic signed [31:0] target_angle;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         joint_id_out;
    logic [5:0]         sample_index;
    logic [31:0]        sample_time;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] acceleration;
    logic               last;
  } out_item_t;

  // One joint run, as queued between front and back
  typedef struct packed {
    logic [2:0]         joint;
    logic signed [31:0] start;
    logic signed [31:0] a2;
    logic signed [31:0] a3;
    logic [NSTEP_W-1:0] n;
    logic [DT_W-1:0]    dt;
  } job_t;

  // Per-sample identity carried down the sample pipeline
  typedef struct packed {
    logic [2:0]  joint;
    logic [5:0]  idx;
    logic [31:0] t;
    logic        last;
  } tag_t;

  typedef struct packed {
    tag_t               tag;
    logic signed [31:0] start;
    logic signed [31:0] a2;
    logic [31:0]        a2m;
    logic [31:0]        a3m;
    logic               a3n;
  } ctx_t;

  // Magnitude of a signed 32-bit value (2^31 fits unsigned)
  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  // Magnitude of a 33-bit difference of two 32-bit values (never -2^32)
  function automatic logic [31:0] mag33(input logic signed [32:0] x);
    logic [32:0] m;
    m = x[32] ? (~x + 33'd1) : x;
    return m[31:0];
  endfunction

  // Apply sign to a rounded magnitude and saturate to signed 32 bits
  function automatic logic signed [31:0] sat_mag(input logic [48:0] r, input logic neg);
    logic big;
    big = |r[48:31];
    if (neg) begin
      return big ? S32_MIN : $signed(32'd0 - r[31:0]);
    end
    return big ? S32_MAX : $signed(r[31:0]);
  endfunction

  // Shift a magnitude product right 16, round half away from zero, saturate
  function automatic logic signed [31:0] rs16(input logic [63:0] p, input logic neg);
    logic [48:0] r;
    r = {1'b0, p[63:16]} + {48'd0, p[15]};
    return sat_mag(r, neg);
  endfunction

  // Same with a 24-bit shift
  function automatic logic signed [31:0] rs24(input logic [63:0] p, input logic neg);
    logic [48:0] r;
    r = {9'd0, p[63:24]} + {48'd0, p[23]};
    return sat_mag(r, neg);
  endfunction

  function automatic logic signed [35:0] sx36(input logic signed [31:0] x);
    return {{4{x[31]}}, x};
  endfunction

  // Saturate a 36-bit signed sum to signed 32 bits
  function automatic logic signed [31:0] sat36(input logic signed [35:0] s);
    if (s[35:31] == {5{s[35]}}) begin
      return s[31:0];
    end
    return s[35] ? S32_MIN : S32_MAX;
  endfunction

endpackage

// ----- hw/rtl/cjt_stream_if.sv -----
// Valid/ready stream channel carrying one payload item per request.
// Payload type is set by the instantiating level; uses no package.
`timescale 1ns / 1ps

interface cjt_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/cjt_front.sv -----
// Front end: takes joint requests, drops unknown joints, forms delta and
// the coefficients a2/a3, and pushes a job. Depends on cjt_pkg, cjt_stream_if.
`timescale 1ns / 1ps

module cjt_front #(
  parameter int MAX_STEPS   = cjt_pkg::MAX_STEPS_DEF,
  parameter int JOINT_COUNT = cjt_pkg::JOINT_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  cjt_stream_if.sink                  in_stream,
  input  logic [cjt_pkg::NSTEP_W-1:0] num_steps,
  input  logic [cjt_pkg::DT_W-1:0]    step_time,
  input  logic signed [31:0]          quad_coeff,
  input  logic signed [31:0]          cubic_coeff,
  output logic                        push_valid,
  input  logic                        push_ready,
  output cjt_pkg::job_t               push_job
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0] state_r, state_nxt;

  logic [2:0]                  joint_r;
  logic signed [31:0]          start_r;
  logic                        dneg_r;
  logic [31:0]                 dmag_r;
  logic [cjt_pkg::NSTEP_W-1:0] n_r;
  logic [cjt_pkg::DT_W-1:0]    dt_r;
  logic [63:0]                 qprod_r, cprod_r;
  logic                        qneg_r, cneg_r;

  logic                        accept, keep;
  logic signed [32:0]          delta_w;
  logic [cjt_pkg::NSTEP_W-1:0] n_w;

  assign in_stream.ready = (state_r == F_IDLE);
  assign accept = in_stream.valid && in_stream.ready;
  assign keep   = {1'b0, in_stream.data.joint_id} < 4'(JOINT_COUNT);

  assign delta_w = {in_stream.data.target_angle[31], in_stream.data.target_angle}
                 - {in_stream.data.start_angle[31], in_stream.data.start_angle};

  // Clamp the run length to 1 .. MAX_STEPS
  always_comb begin
    n_w = num_steps;
    if (num_steps == '0) begin
      n_w = cjt_pkg::NSTEP_W'(1);
    end else if (num_steps > cjt_pkg::NSTEP_W'(MAX_STEPS)) begin
      n_w = cjt_pkg::NSTEP_W'(MAX_STEPS);
    end
  end

  // Advance: idle -> multiply -> push
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (accept && keep) state_nxt = F_MUL;
      F_MUL:  state_nxt = F_PUSH;
      F_PUSH: if (push_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (accept && keep) begin
      joint_r <= in_stream.data.joint_id;
      start_r <= in_stream.data.start_angle;
      dneg_r  <= delta_w[32];
      dmag_r  <= cjt_pkg::mag33(delta_w);
      n_r     <= n_w;
      dt_r    <= step_time;
    end
  end

  // Coefficient times delta, on magnitudes
  always_ff @(posedge clk) begin
    if (state_r == F_MUL) begin
      qprod_r <= cjt_pkg::mag32(quad_coeff) * dmag_r;
      cprod_r <= cjt_pkg::mag32(cubic_coeff) * dmag_r;
      qneg_r  <= quad_coeff[31] ^ dneg_r;
      cneg_r  <= cubic_coeff[31] ^ dneg_r;
    end
  end

  assign push_valid     = (state_r == F_PUSH);
  assign push_job.joint = joint_r;
  assign push_job.start = start_r;
  assign push_job.a2    = cjt_pkg::rs24(qprod_r, qneg_r);
  assign push_job.a3    = cjt_pkg::rs24(cprod_r, cneg_r);
  assign push_job.n     = n_r;
  assign push_job.dt    = dt_r;

endmodule

// ----- hw/rtl/cjt_job_fifo.sv -----
// Short job queue between front and back end.
// Depends on cjt_pkg for the job type.
`timescale 1ns / 1ps

module cjt_job_fifo #(
  parameter int DEPTH = cjt_pkg::JOB_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  cjt_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output cjt_pkg::job_t pop_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cjt_pkg::job_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push, pop;

  assign push_ready = (cnt_r < CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = mem_r[rd_ptr_r];

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/cjt_back.sv -----
// Back end: steps through one job's samples and evaluates the cubic in a
// seven-stage multiply pipeline. Depends on cjt_pkg, cjt_stream_if.
`timescale 1ns / 1ps

module cjt_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  cjt_pkg::job_t pop_job,
  cjt_stream_if.source  out_stream
);

  // Sample sequencer
  logic                        act_r;
  logic [cjt_pkg::NSTEP_W-1:0] i_r, n_r;
  logic [31:0]                 t_r;
  logic [cjt_pkg::DT_W-1:0]    dt_r;
  logic [2:0]                  joint_r;
  logic signed [31:0]          start_r, a2_r;
  logic [31:0]                 a2m_r, a3m_r;
  logic                        a3n_r;

  logic        en, pop, issue, last_w;
  cjt_pkg::ctx_t c0;

  // Pipeline stages
  logic          v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, out_valid_r;
  cjt_pkg::ctx_t c1_r, c2_r, c3_r, c4_r, c5_r, c6_r;
  logic [63:0]   s1_tt_r, s1_a2t_r, s1_a3t_r;
  logic [31:0]   s2_t2_r;
  logic signed [31:0] s2_a2t_r, s2_a3t_r;
  logic [63:0]   s3_t3p_r, s3_a2t2p_r, s3_a3t2p_r;
  logic signed [31:0] s3_a2t_r, s3_acc_r;
  logic [31:0]   s4_t3_r;
  logic signed [31:0] s4_a2t2_r, s4_a3t2_r, s4_a2t_r, s4_acc_r;
  logic [63:0]   s5_a3t3p_r;
  logic signed [31:0] s5_a2t2_r, s5_vel_r, s5_acc_r;
  logic signed [31:0] s6_a3t3_r, s6_a2t2_r, s6_vel_r, s6_acc_r;
  cjt_pkg::out_item_t out_data_r;

  assign en        = !out_valid_r || out_stream.ready;
  assign pop_ready = !act_r;
  assign pop       = pop_valid && !act_r;
  assign issue     = act_r && en;
  assign last_w    = (i_r == n_r - cjt_pkg::NSTEP_W'(1));

  assign c0.tag.joint = joint_r;
  assign c0.tag.idx   = i_r[5:0];
  assign c0.tag.t     = t_r;
  assign c0.tag.last  = last_w;
  assign c0.start     = start_r;
  assign c0.a2        = a2_r;
  assign c0.a2m       = a2m_r;
  assign c0.a3m       = a3m_r;
  assign c0.a3n       = a3n_r;

  // Run control: load a job, drop back to idle after its final sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else if (pop) begin
      act_r <= 1'b1;
    end else if (issue && last_w) begin
      act_r <= 1'b0;
    end
  end

  // Load job fields, then advance sample index and time
  always_ff @(posedge clk) begin
    if (pop) begin
      i_r     <= '0;
      t_r     <= '0;
      n_r     <= pop_job.n;
      dt_r    <= pop_job.dt;
      joint_r <= pop_job.joint;
      start_r <= pop_job.start;
      a2_r    <= pop_job.a2;
      a2m_r   <= cjt_pkg::mag32(pop_job.a2);
      a3m_r   <= cjt_pkg::mag32(pop_job.a3);
      a3n_r   <= pop_job.a3[31];
    end else if (issue) begin
      i_r <= i_r + cjt_pkg::NSTEP_W'(1);
      t_r <= t_r + {12'd0, dt_r};
    end
  end

  // Valid bits move with the pipeline; hold everything while the output stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= issue;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      out_valid_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // t^2, a2*t, a3*t
      c1_r     <= c0;
      s1_tt_r  <= c0.tag.t * c0.tag.t;
      s1_a2t_r <= c0.a2m * c0.tag.t;
      s1_a3t_r <= c0.a3m * c0.tag.t;

      // Round the first products
      c2_r     <= c1_r;
      s2_t2_r  <= cjt_pkg::rs16(s1_tt_r, 1'b0);
      s2_a2t_r <= cjt_pkg::rs16(s1_a2t_r, c1_r.a2[31]);
      s2_a3t_r <= cjt_pkg::rs16(s1_a3t_r, c1_r.a3n);

      // t^3, a2*t^2, a3*t^2; acceleration
      c3_r       <= c2_r;
      s3_t3p_r   <= s2_t2_r * c2_r.tag.t;
      s3_a2t2p_r <= c2_r.a2m * s2_t2_r;
      s3_a3t2p_r <= c2_r.a3m * s2_t2_r;
      s3_a2t_r   <= s2_a2t_r;
      s3_acc_r   <= cjt_pkg::sat36((cjt_pkg::sx36(c2_r.a2) <<< 1)
                                   + (cjt_pkg::sx36(s2_a3t_r) <<< 2)
                                   + (cjt_pkg::sx36(s2_a3t_r) <<< 1));

      // Round the second products
      c4_r      <= c3_r;
      s4_t3_r   <= cjt_pkg::rs16(s3_t3p_r, 1'b0);
      s4_a2t2_r <= cjt_pkg::rs16(s3_a2t2p_r, c3_r.a2[31]);
      s4_a3t2_r <= cjt_pkg::rs16(s3_a3t2p_r, c3_r.a3n);
      s4_a2t_r  <= s3_a2t_r;
      s4_acc_r  <= s3_acc_r;

      // a3*t^3; velocity
      c5_r       <= c4_r;
      s5_a3t3p_r <= c4_r.a3m * s4_t3_r;
      s5_a2t2_r  <= s4_a2t2_r;
      s5_vel_r   <= cjt_pkg::sat36((cjt_pkg::sx36(s4_a2t_r) <<< 1)
                                   + (cjt_pkg::sx36(s4_a3t2_r) <<< 1)
                                   + cjt_pkg::sx36(s4_a3t2_r));
      s5_acc_r   <= s4_acc_r;

      // Round the cubic term
      c6_r      <= c5_r;
      s6_a3t3_r <= cjt_pkg::rs16(s5_a3t3p_r, c5_r.a3n);
      s6_a2t2_r <= s5_a2t2_r;
      s6_vel_r  <= s5_vel_r;
      s6_acc_r  <= s5_acc_r;

      // Position and the output register
      out_data_r.joint_id_out <= c6_r.tag.joint;
      out_data_r.sample_index <= c6_r.tag.idx;
      out_data_r.sample_time  <= c6_r.tag.t;
      out_data_r.position     <= cjt_pkg::sat36(cjt_pkg::sx36(c6_r.start)
                                                + cjt_pkg::sx36(s6_a2t2_r)
                                                + cjt_pkg::sx36(s6_a3t3_r));
      out_data_r.velocity     <= s6_vel_r;
      out_data_r.acceleration <= s6_acc_r;
      out_data_r.last         <= c6_r.tag.last;
    end
  end

  assign out_stream.valid = out_valid_r;
  assign out_stream.data  = out_data_r;

endmodule

// ----- hw/rtl/cubic_joint_trajectory_gen.sv -----
// Cubic joint trajectory generator top level: configuration registers, front
// end, job queue and sample back end. Depends on cjt_pkg and all cjt_* files.
//
// Usage: in_stream carries one request per joint move (joint_id, start and
// target angle). Each request with joint_id below JOINT_COUNT yields num_steps
// samples on out_stream (clamped to 1 .. MAX_STEPS), the final one with last
// set; other requests are taken and dropped. Registers are written through
// cfg_we/cfg_index/cfg_wdata; the user must write them only while the block
// is idle, which the block itself does not enforce. The front end holds a kept
// request, forms a2/a3 from it and pushes a job; the job queue stores the job
// and the back end loads it and runs its samples through the pipeline.
// Throughput: the back end issues one sample per cycle while the output is
// not stalled, and loads the next job only after it issues the final sample
// of the current one; the front end takes no new request until it has pushed
// the last job, and the job queue lets it work ahead of the back end.
// Reset (rst_n low, synchronous) empties the pipeline and queue and loads the
// register defaults. When the receiver holds ready low the whole sample
// pipeline holds; the front end keeps filling the queue until it is full.
`timescale 1ns / 1ps

module cubic_joint_trajectory_gen #(
  parameter int MAX_STEPS   = cjt_pkg::MAX_STEPS_DEF,
  parameter int JOINT_COUNT = cjt_pkg::JOINT_COUNT_DEF,
  parameter int JOB_DEPTH   = cjt_pkg::JOB_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  cjt_stream_if.sink                     in_stream,
  cjt_stream_if.source                   out_stream,
  input  logic                           cfg_we,
  input  logic [cjt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cjt_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [cjt_pkg::NSTEP_W-1:0] num_steps_r;
  logic [cjt_pkg::DT_W-1:0]    step_time_r;
  logic signed [31:0]          quad_coeff_r, cubic_coeff_r;

  logic          push_valid, push_ready, pop_valid, pop_ready;
  cjt_pkg::job_t push_job, pop_job;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_steps_r   <= cjt_pkg::NUM_STEPS_RST;
      step_time_r   <= cjt_pkg::STEP_TIME_RST;
      quad_coeff_r  <= cjt_pkg::QUAD_COEFF_RST;
      cubic_coeff_r <= cjt_pkg::CUBIC_COEFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cjt_pkg::CFG_NUM_STEPS:   num_steps_r   <= cfg_wdata[cjt_pkg::NSTEP_W-1:0];
        cjt_pkg::CFG_STEP_TIME:   step_time_r   <= cfg_wdata[cjt_pkg::DT_W-1:0];
        cjt_pkg::CFG_QUAD_COEFF:  quad_coeff_r  <= $signed(cfg_wdata[31:0]);
        cjt_pkg::CFG_CUBIC_COEFF: cubic_coeff_r <= $signed(cfg_wdata[31:0]);
      endcase
    end
  end

  cjt_front #(
    .MAX_STEPS   (MAX_STEPS),
    .JOINT_COUNT (JOINT_COUNT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stream   (in_stream),
    .num_steps   (num_steps_r),
    .step_time   (step_time_r),
    .quad_coeff  (quad_coeff_r),
    .cubic_coeff (cubic_coeff_r),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_job    (push_job)
  );

  cjt_job_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  cjt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job),
    .out_stream (out_stream)
  );

endmodule

// ----- tb/sv/cubic_joint_trajectory_gen_tb.sv -----
// Self-checking testbench for the cubic joint trajectory generator: joint moves in,
// trajectory samples out, every field checked against an in-bench predictor.
// Depends on cjt_pkg, cjt_stream_if and cubic_joint_trajectory_gen.
`timescale 1ns / 1ps

module cubic_joint_trajectory_gen_tb;

  localparam int     CYCLE_LIMIT = 600000;
  localparam int     SETTLE      = 40;
  localparam int     LONG_HOLD   = 400;
  localparam int     PHASES      = 8;
  localparam int     PHASE_MOVES = 28;
  localparam longint SAT_HI      = 64'sd2147483647;
  localparam longint SAT_LO      = -64'sd2147483648;

  // Predicts the sample run of each accepted joint move and checks the samples
  class trajectory_book;
    logic [cjt_pkg::NSTEP_W-1:0] num_steps;
    logic [cjt_pkg::DT_W-1:0]    step_time;
    logic signed [31:0]          quad_coeff;
    logic signed [31:0]          cubic_coeff;
    cjt_pkg::out_item_t          expected_samples[$];
    int                          errors;

    function new();
      num_steps   = cjt_pkg::NUM_STEPS_RST;
      step_time   = cjt_pkg::STEP_TIME_RST;
      quad_coeff  = cjt_pkg::QUAD_COEFF_RST;
      cubic_coeff = cjt_pkg::CUBIC_COEFF_RST;
      errors      = 0;
    endfunction

    function void set_reg(logic [cjt_pkg::CFG_IDX_W-1:0] idx,
                          logic [cjt_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        cjt_pkg::CFG_NUM_STEPS:   num_steps   = data[cjt_pkg::NSTEP_W-1:0];
        cjt_pkg::CFG_STEP_TIME:   step_time   = data[cjt_pkg::DT_W-1:0];
        cjt_pkg::CFG_QUAD_COEFF:  quad_coeff  = data;
        cjt_pkg::CFG_CUBIC_COEFF: cubic_coeff = data;
        default: ;
      endcase
    endfunction

    // Exact product of magnitudes, shift, round half away from zero, saturate
    function longint mul_round(longint a, longint b, int unsigned shift);
      bit        neg;
      bit [63:0] ma, mb, p, r;
      neg = (a < 0) != (b < 0);
      ma  = (a < 0) ? -a : a;
      mb  = (b < 0) ? -b : b;
      p   = ma * mb;
      r   = (p >> shift) + ((p >> (shift - 1)) & 64'd1);
      if (neg) begin
        return (r >= 64'h8000_0000) ? SAT_LO : -longint'(r);
      end
      return (r >= 64'h7FFF_FFFF) ? SAT_HI : longint'(r);
    endfunction

    function longint clip32(longint x);
      if (x > SAT_HI) begin
        return SAT_HI;
      end
      if (x < SAT_LO) begin
        return SAT_LO;
      end
      return x;
    endfunction

    // Queue the whole sample run that one accepted request produces
    function void note_move(cjt_pkg::in_item_t mv);
      int unsigned        n;
      longint             start, delta, a2, a3, t, t2, t3;
      logic [31:0]        elapsed;
      cjt_pkg::out_item_t s;
      // drop joints the block does not drive
      if (mv.joint_id >= cjt_pkg::JOINT_COUNT_DEF) begin
        return;
      end
      n = num_steps;
      if (n < 1) begin
        n = 1;
      end
      if (n > cjt_pkg::MAX_STEPS_DEF) begin
        n = cjt_pkg::MAX_STEPS_DEF;
      end
      start   = longint'($signed(mv.start_angle));
      delta   = longint'($signed(mv.target_angle)) - start;
      a2      = mul_round(quad_coeff, delta, 24);
      a3      = mul_round(cubic_coeff, delta, 24);
      elapsed = '0;
      for (int i = 0; i < n; i++) begin
        t  = elapsed;
        t2 = mul_round(t, t, 16);
        t3 = mul_round(t2, t, 16);
        s.joint_id_out = mv.joint_id;
        s.sample_index = 6'(i);
        s.sample_time  = elapsed;
        s.position     = 32'(clip32(start + mul_round(a2, t2, 16) + mul_round(a3, t3, 16)));
        s.velocity     = 32'(clip32(2 * mul_round(a2, t, 16) + 3 * mul_round(a3, t2, 16)));
        s.acceleration = 32'(clip32(2 * a2 + 6 * mul_round(a3, t, 16)));
        s.last         = (i == n - 1);
        expected_samples.insert(expected_samples.size(), s);
        // advance the sample clock, wrapping at 32 bits
        elapsed += step_time;
      end
    endfunction

    function void compare(string field, logic signed [63:0] want, logic signed [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_sample(cjt_pkg::out_item_t got);
      cjt_pkg::out_item_t want;
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected sample: expected none, got joint %0d index %0d",
                 $time, got.joint_id_out, got.sample_index);
        errors++;
        return;
      end
      want = expected_samples.pop_front();
      compare("joint_id_out", want.joint_id_out, got.joint_id_out);
      compare("sample_index", want.sample_index, got.sample_index);
      compare("sample_time", want.sample_time, got.sample_time);
      compare("position", $signed(want.position), $signed(got.position));
      compare("velocity", $signed(want.velocity), $signed(got.velocity));
      compare("acceleration", $signed(want.acceleration), $signed(got.acceleration));
      compare("last", want.last, got.last);
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [cjt_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cjt_pkg::CFG_DATA_W-1:0] cfg_wdata;
  bit                             idle_on    = 1'b1;
  int                             hold_left  = 0;
  int                             stall_left = 0;
  trajectory_book                 book       = new();

  cjt_stream_if #(.T(cjt_pkg::in_item_t))  in_stream ();
  cjt_stream_if #(.T(cjt_pkg::out_item_t)) out_stream ();

  cubic_joint_trajectory_gen dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_stream),
    .out_stream (out_stream),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: long hold-off first, then the per-sample stall drawn at acceptance
  initial begin
    out_stream.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stream.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stream.ready <= 1'b0;
        stall_left--;
      end else begin
        out_stream.ready <= 1'b1;
      end
    end
  end

  // Check each accepted sample and draw the stall before the next one
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_stream.valid === 1'b1 && out_stream.ready === 1'b1) begin
      book.check_sample(out_stream.data);
      stall_left = idle_on ? $urandom_range(0, 4) : 0;
    end
  end

  // Watchdog
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL cubic_joint_trajectory_gen");
    $finish;
  end

  function automatic cjt_pkg::in_item_t make_move(logic [2:0] jid, logic [31:0] from,
                                                  logic [31:0] to);
    cjt_pkg::in_item_t mv;
    mv.joint_id     = jid;
    mv.start_angle  = from;
    mv.target_angle = to;
    return mv;
  endfunction

  function automatic logic [31:0] extreme_word();
    case ($urandom_range(0, 4))
      0:       return cjt_pkg::S32_MIN;
      1:       return cjt_pkg::S32_MAX;
      2:       return 32'd0;
      3:       return 32'hFFFF_FFFF;
      default: return 32'd1;
    endcase
  endfunction

  // Mostly plausible joint moves, some full-scale and extreme ones, a few dropped joints
  function automatic cjt_pkg::in_item_t random_move();
    logic [2:0]  jid;
    logic [31:0] from, to;
    jid = ($urandom_range(0, 9) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
    case ($urandom_range(0, 9))
      0: begin
        from = $urandom();
        to   = $urandom();
      end
      1: begin
        from = extreme_word();
        to   = extreme_word();
      end
      default: begin
        from = 32'($urandom_range(0, 524288)) - 32'd262144;
        to   = from + 32'($urandom_range(0, 524288)) - 32'd262144;
      end
    endcase
    return make_move(jid, from, to);
  endfunction

  // Offer one request after a random gap and hold it until it is taken
  task automatic send_move(cjt_pkg::in_item_t mv);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_stream.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_stream.valid <= 1'b1;
    in_stream.data  <= mv;
    do begin
      @(posedge clk);
    end while (in_stream.ready !== 1'b1);
    book.note_move(mv);
  endtask

  // Stop offering, wait for every predicted sample, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    in_stream.valid <= 1'b0;
    while (book.expected_samples.size() > 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [cjt_pkg::CFG_IDX_W-1:0] idx,
                           logic [cjt_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    book.set_reg(idx, data);
  endtask

  // Write all four registers; unused upper bits of the narrow ones carry junk
  task automatic load_regs(logic [cjt_pkg::NSTEP_W-1:0] n, logic [cjt_pkg::DT_W-1:0] dt,
                           logic [31:0] quad, logic [31:0] cubic);
    logic [cjt_pkg::CFG_DATA_W-1:0] junk;
    junk = $urandom();
    write_reg(cjt_pkg::CFG_NUM_STEPS,
              {junk[cjt_pkg::CFG_DATA_W-1:cjt_pkg::NSTEP_W], n});
    junk = $urandom();
    write_reg(cjt_pkg::CFG_STEP_TIME,
              {junk[cjt_pkg::CFG_DATA_W-1:cjt_pkg::DT_W], dt});
    write_reg(cjt_pkg::CFG_QUAD_COEFF, quad);
    write_reg(cjt_pkg::CFG_CUBIC_COEFF, cubic);
  endtask

  initial begin
    cjt_pkg::in_item_t mv;
    int                sent;
    int unsigned       steps;
    real               span;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    in_stream.valid = 1'b0;
    in_stream.data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE) @(posedge clk);

    // Reset settings: still joint, quarter turn, full-scale swings, dropped joint
    send_move(make_move(3'd0, 32'd0, 32'd0));
    send_move(make_move(3'd1, 32'd0, 32'sd102944));
    send_move(make_move(3'd2, cjt_pkg::S32_MIN, cjt_pkg::S32_MAX));
    send_move(make_move(3'd3, cjt_pkg::S32_MAX, cjt_pkg::S32_MIN));
    send_move(make_move(3'd7, $urandom(), $urandom()));
    send_move(make_move(3'd6, cjt_pkg::S32_MAX, cjt_pkg::S32_MAX));
    send_move(make_move(3'd4, cjt_pkg::S32_MIN, cjt_pkg::S32_MIN));
    send_move(make_move(3'd5, -32'sd1, 32'sd1));
    drain();

    // Zero step count runs as one sample; zero step time holds time at zero
    load_regs(7'd0, 20'd0, cjt_pkg::QUAD_COEFF_RST, cjt_pkg::CUBIC_COEFF_RST);
    send_move(make_move(3'd2, 32'sd65536, -32'sd65536));
    send_move(make_move(3'd7, cjt_pkg::S32_MIN, cjt_pkg::S32_MAX));
    send_move(make_move(3'd6, cjt_pkg::S32_MIN, cjt_pkg::S32_MAX));
    drain();

    // Oversized step count clamps to the maximum; longest step, extreme coefficients
    load_regs(7'd127, 20'hFFFFF, cjt_pkg::S32_MAX, cjt_pkg::S32_MIN);
    send_move(make_move(3'd1, cjt_pkg::S32_MIN, cjt_pkg::S32_MAX));
    send_move(make_move(3'd5, 32'sd205887, -32'sd205887));
    drain();

    load_regs(7'd64, 20'd1, cjt_pkg::S32_MIN, cjt_pkg::S32_MAX);
    send_move(make_move(3'd0, cjt_pkg::S32_MAX, cjt_pkg::S32_MIN));
    send_move(make_move(3'd3, -32'sd1000, 32'sd1000));
    drain();

    load_regs(7'd1, 20'd6554, 32'd0, 32'd0);
    send_move(make_move(3'd4, 32'sd12345, -32'sd54321));
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      idle_on = (phase % 3) != 1;
      // Pick this phase's settings: plausible move duration, random, or extremes
      case ((phase == 0) ? 0 : $urandom_range(0, 3))
        0, 1: begin
          steps = (phase == 0) ? 64 : $urandom_range(1, 64);
          span  = 1.0 + real'($urandom_range(0, 9000)) / 1000.0;
          load_regs(7'(steps), 20'($rtoi(span / steps * 65536.0)),
                    32'($rtoi(3.0 / (span * span) * 16777216.0)),
                    32'(-$rtoi(2.0 / (span * span * span) * 16777216.0)));
        end
        2: begin
          load_regs(7'($urandom_range(0, 127)), 20'($urandom_range(0, 20'hFFFFF)),
                    $urandom(), $urandom());
        end
        default: begin
          case ($urandom_range(0, 3))
            0:       steps = 0;
            1:       steps = 1;
            2:       steps = 64;
            default: steps = 127;
          endcase
          load_regs(7'(steps), 20'(extreme_word()), extreme_word(), extreme_word());
        end
      endcase

      sent = 0;
      while (sent < PHASE_MOVES) begin
        mv = random_move();
        if (mv.joint_id < cjt_pkg::JOINT_COUNT_DEF) begin
          sent++;
        end
        send_move(mv);
        // hold off the receiver so the job queue fills and the input stalls
        if (phase == 0 && sent == 5) begin
          hold_left = LONG_HOLD;
        end
        // pause the sender until the block has emptied
        if (phase == 4 && sent == 16) begin
          drain();
        end
      end
      drain();
    end

    if (book.errors == 0 && book.expected_samples.size() == 0) begin
      $display("PASS cubic_joint_trajectory_gen");
    end else begin
      $display("FAIL cubic_joint_trajectory_gen");
    end
    $finish;
  end

endmodule
